### rtl/core/hbin_pkg.sv
// Shared types and constants for the 2-D variable-edge histogram binner.
// Holds field widths, command and status codes, and the control/status
// bundles passed between the controller and the datapath.
package hbin_pkg;

    localparam int COORD_W  = 32;
    localparam int EDGE_W   = 32;
    localparam int WEIGHT_W = 32;
    localparam int BIN_W    = 48;
    localparam int IDX_A_W  = 7;
    localparam int IDX_B_W  = 6;
    localparam int FOUND_W  = 6;
    localparam int NBINS_W  = 7;
    localparam int STAT_W   = 2;
    localparam int FRAC_W   = 16;   // Q16.16: one unit is 1 << FRAC_W

    typedef logic [2:0] t_cmd_code;
    localparam t_cmd_code CMD_WR_X  = 3'd0;
    localparam t_cmd_code CMD_WR_Y  = 3'd1;
    localparam t_cmd_code CMD_INC   = 3'd2;
    localparam t_cmd_code CMD_READ  = 3'd3;
    localparam t_cmd_code CMD_CLEAR = 3'd4;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_X_RANGE   = 2'd1;
    localparam t_status STAT_Y_RANGE   = 2'd2;
    localparam t_status STAT_BAD_INDEX = 2'd3;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_X_BINS = 1'b0;
    localparam t_cfg_idx CFG_Y_BINS = 1'b1;

    localparam logic [NBINS_W-1:0] NBINS_RESET = 7'd64;

    localparam logic [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
    localparam logic [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

    // Where the result value comes from
    typedef logic [1:0] t_res_src;
    localparam t_res_src SRC_ZERO = 2'd0;
    localparam t_res_src SRC_READ = 2'd1;
    localparam t_res_src SRC_INC  = 2'd2;

    typedef struct packed {
        logic     capture;
        logic     srch_start;
        logic     edge_wr;
        logic     bin_rd;
        logic     bin_upd;
        logic     sweep;
        logic     sweep_init;
        logic     out_load;
        t_status  out_status;
        t_res_src out_src;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      edge_ok;
        logic      rd_ok;
        logic      srch_done;
        logic      x_ok;
        logic      y_ok;
        logic      sweep_last;
    } t_dp_stat;

    typedef struct packed {
        logic done;
        logic ok;
    } t_srch_stat;

endpackage

### rtl/core/hbin_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hbin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/hbin_search.sv
// One axis: edge table in RAM plus a binary search, one probe per cycle.
// Depends on hbin_pkg and hbin_ram.
module hbin_search #(
    parameter int MAX_BINS = 64,
    localparam int AW = $clog2(MAX_BINS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [hbin_pkg::COORD_W-1:0]  i_value,
    input  logic [AW-1:0]                        i_nbins,
    input  logic                                 i_wr_en,
    input  logic [AW-1:0]                        i_wr_addr,
    input  logic [hbin_pkg::EDGE_W-1:0]          i_wr_data,
    output hbin_pkg::t_srch_stat                 o_stat,
    output logic [AW-1:0]                        o_bin
);

    import hbin_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_E0   = 2'd1;
    localparam logic [1:0] PH_EN   = 2'd2;
    localparam logic [1:0] PH_STEP = 2'd3;

    logic [1:0]        r_ph, n_ph;
    logic              r_done, n_done;
    logic              r_ok, n_ok;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_mid, n_mid;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [EDGE_W-1:0] rd_data;
    logic              v_ge;
    logic [AW-1:0]     a_lo, a_hi;
    logic [AW:0]       span_sum;
    logic              more;

    hbin_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_BINS + 1)
    ) u_edges (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign v_ge = i_value >= $signed(rd_data);

    always_comb begin
        n_ph    = r_ph;
        n_done  = r_done;
        n_ok    = r_ok;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        rd_en   = 1'b0;
        rd_addr = '0;
        a_lo    = '0;
        a_hi    = i_nbins;
        if (r_ph == PH_STEP) begin
            a_lo = v_ge ? r_mid : r_lo;
            a_hi = v_ge ? r_hi : r_mid;
        end
        span_sum = {1'b0, a_lo} + {1'b0, a_hi};
        more     = (a_hi - a_lo) > AW'(1);

        if (i_start) begin
            rd_en  = 1'b1;
            n_ph   = PH_E0;
            n_done = 1'b0;
            n_ok   = 1'b1;
        end else begin
            case (r_ph)
                PH_E0: begin
                    // lower edge is inclusive
                    n_ok    = v_ge;
                    rd_en   = 1'b1;
                    rd_addr = i_nbins;
                    n_ph    = PH_EN;
                end
                PH_EN, PH_STEP: begin
                    n_lo = a_lo;
                    n_hi = a_hi;
                    if (r_ph == PH_EN) begin
                        // upper edge is exclusive
                        n_ok = r_ok && !v_ge;
                    end
                    if (n_ok && more) begin
                        rd_en   = 1'b1;
                        rd_addr = span_sum[AW:1];
                        n_mid   = span_sum[AW:1];
                        n_ph    = PH_STEP;
                    end else begin
                        n_ph   = PH_IDLE;
                        n_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
            r_ok   <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

    assign o_stat = '{done: r_done, ok: r_ok};
    assign o_bin  = r_lo;

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_STEP) |-> ((r_lo < r_mid) && (r_mid < r_hi)))
        else $error("search probe outside the open interval");

    a_found_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_ok) |-> (r_hi == r_lo + AW'(1)))
        else $error("search finished without narrowing to one bin");

endmodule

### rtl/core/hbin_ctrl.sv
// Controller state machine for the histogram binner: sequences the
// datapath through each command. Depends on hbin_pkg.
module hbin_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  hbin_pkg::t_dp_stat i_stat,
    output hbin_pkg::t_dp_cmd  o_cmd
);

    import hbin_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_BRD   = 3'd4;
    localparam logic [2:0] S_BDATA = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = STAT_BAD_INDEX;
        o_cmd.out_src    = SRC_ZERO;
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_out_ready;

        // result decode, used only when the output register is loaded
        case (i_stat.cmd)
            CMD_WR_X, CMD_WR_Y: begin
                o_cmd.out_status = i_stat.edge_ok ? STAT_OK : STAT_BAD_INDEX;
            end
            CMD_INC: begin
                if (!i_stat.x_ok) begin
                    o_cmd.out_status = STAT_X_RANGE;
                end else if (!i_stat.y_ok) begin
                    o_cmd.out_status = STAT_Y_RANGE;
                end else begin
                    o_cmd.out_status = STAT_OK;
                    o_cmd.out_src    = SRC_INC;
                end
            end
            CMD_READ: begin
                if (i_stat.rd_ok) begin
                    o_cmd.out_status = STAT_OK;
                    o_cmd.out_src    = SRC_READ;
                end
            end
            CMD_CLEAR: begin
                o_cmd.out_status = STAT_OK;
            end
            default: begin
                o_cmd.out_status = STAT_BAD_INDEX;
            end
        endcase

        case (r_state)
            S_INIT: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_init = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_WR_X, CMD_WR_Y: begin
                        o_cmd.edge_wr = i_stat.edge_ok;
                        n_state       = S_DONE;
                    end
                    CMD_INC: begin
                        o_cmd.srch_start = 1'b1;
                        n_state          = S_SRCH;
                    end
                    CMD_READ: begin
                        n_state = i_stat.rd_ok ? S_BRD : S_DONE;
                    end
                    CMD_CLEAR: begin
                        n_state = S_CLR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SRCH: begin
                if (i_stat.srch_done) begin
                    n_state = (i_stat.x_ok && i_stat.y_ok) ? S_BRD : S_DONE;
                end
            end
            S_BRD: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_BDATA;
            end
            S_BDATA: begin
                o_cmd.bin_upd = (i_stat.cmd == CMD_INC);
                n_state       = S_DONE;
            end
            S_CLR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for room in the output register
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the completion state");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.bin_upd |-> $past(o_cmd.bin_rd))
        else $error("bin update without a preceding bin read");

endmodule

### rtl/core/hbin_dpath.sv
// Datapath of the histogram binner: payload and config registers, two axis
// searches, the bin store with saturating update, result registers.
// Depends on hbin_pkg, hbin_search and hbin_ram.
module hbin_dpath #(
    parameter int MAX_X_BINS = 64,
    parameter int MAX_Y_BINS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hbin_pkg::t_dp_cmd                    i_ctl,
    output hbin_pkg::t_dp_stat                   o_sts,
    input  hbin_pkg::t_cmd_code                  i_cmd,
    input  logic signed [hbin_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [hbin_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [hbin_pkg::WEIGHT_W-1:0] i_weight,
    input  logic signed [hbin_pkg::EDGE_W-1:0]   i_edge_value,
    input  logic [hbin_pkg::IDX_A_W-1:0]         i_index_a,
    input  logic [hbin_pkg::IDX_B_W-1:0]         i_index_b,
    input  logic                                 i_cfg_wr,
    input  hbin_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [hbin_pkg::NBINS_W-1:0]         i_cfg_data,
    output hbin_pkg::t_status                    o_status,
    output logic signed [hbin_pkg::BIN_W-1:0]    o_bin_value,
    output logic [hbin_pkg::FOUND_W-1:0]         o_found_x,
    output logic [hbin_pkg::FOUND_W-1:0]         o_found_y
);

    import hbin_pkg::*;

    localparam int AXW   = $clog2(MAX_X_BINS + 1);
    localparam int AYW   = $clog2(MAX_Y_BINS + 1);
    localparam int DEPTH = MAX_X_BINS * MAX_Y_BINS;
    localparam int BW    = $clog2(DEPTH);
    localparam int NXW   = (AXW > NBINS_W) ? AXW : NBINS_W;
    localparam int NYW   = (AYW > NBINS_W) ? AYW : NBINS_W;

    t_cmd_code                  r_cmd;
    logic signed [COORD_W-1:0]  r_cx, r_cy;
    logic signed [WEIGHT_W-1:0] r_w;
    logic [EDGE_W-1:0]          r_ev;
    logic [IDX_A_W-1:0]         r_ia;
    logic [IDX_B_W-1:0]         r_ib;
    logic [NBINS_W-1:0]         r_xbins, r_ybins;
    logic [BW-1:0]              r_sweep;
    logic [BW-1:0]              r_baddr;
    t_status                    r_status;
    logic [BIN_W-1:0]           r_value;
    logic [FOUND_W-1:0]         r_fx, r_fy;

    logic [NXW-1:0]    xbins_ext, nx_full, ia_x;
    logic [NYW-1:0]    ybins_ext, ny_full, ia_y, ib_y;
    logic [AXW-1:0]    nx, x_bin, x_wa;
    logic [AYW-1:0]    ny, y_bin, y_wa;
    t_srch_stat        x_stat, y_stat;
    logic              edge_ok, rd_ok, sweep_last;
    logic              x_init_ok, y_init_ok, x_we, y_we;
    logic [EDGE_W-1:0] init_edge, x_wd, y_wd;
    logic [BW-1:0]     rd_addr, inc_addr;
    logic              bin_we;
    logic [BW-1:0]     bin_wa;
    logic [BIN_W-1:0]  bin_wd, bin_rd_data;
    logic [BIN_W:0]    sum_ext;
    logic [BIN_W-1:0]  sat_sum;

    // bin counts in use: zero acts as one, above the maximum acts as the maximum
    assign xbins_ext = NXW'(r_xbins);
    assign ybins_ext = NYW'(r_ybins);
    assign nx_full   = (r_xbins == '0) ? NXW'(1) :
                       (xbins_ext > NXW'(MAX_X_BINS)) ? NXW'(MAX_X_BINS) : xbins_ext;
    assign ny_full   = (r_ybins == '0) ? NYW'(1) :
                       (ybins_ext > NYW'(MAX_Y_BINS)) ? NYW'(MAX_Y_BINS) : ybins_ext;
    assign nx        = AXW'(nx_full);
    assign ny        = AYW'(ny_full);

    assign ia_x    = NXW'(r_ia);
    assign ia_y    = NYW'(r_ia);
    assign ib_y    = NYW'(r_ib);
    assign edge_ok = (r_cmd == CMD_WR_X) ? (ia_x <= NXW'(MAX_X_BINS))
                                         : (ia_y <= NYW'(MAX_Y_BINS));
    assign rd_ok   = (ia_x < nx_full) && (ib_y < ny_full);

    assign rd_addr  = BW'(r_ia) * BW'(MAX_Y_BINS) + BW'(r_ib);
    assign inc_addr = BW'(x_bin) * BW'(MAX_Y_BINS) + BW'(y_bin);

    assign sweep_last = (r_sweep == BW'(DEPTH - 1));

    // reset sweep also loads edge i with i in Q16.16
    assign x_init_ok = (BW+1)'(r_sweep) <= (BW+1)'(MAX_X_BINS);
    assign y_init_ok = (BW+1)'(r_sweep) <= (BW+1)'(MAX_Y_BINS);
    assign init_edge = EDGE_W'(r_sweep) << FRAC_W;
    assign x_we = i_ctl.sweep_init ? x_init_ok : (i_ctl.edge_wr && (r_cmd == CMD_WR_X));
    assign y_we = i_ctl.sweep_init ? y_init_ok : (i_ctl.edge_wr && (r_cmd == CMD_WR_Y));
    assign x_wa = i_ctl.sweep_init ? AXW'(r_sweep) : AXW'(r_ia);
    assign y_wa = i_ctl.sweep_init ? AYW'(r_sweep) : AYW'(r_ia);
    assign x_wd = i_ctl.sweep_init ? init_edge : r_ev;
    assign y_wd = i_ctl.sweep_init ? init_edge : r_ev;

    hbin_search #(
        .MAX_BINS (MAX_X_BINS)
    ) u_xsrch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_ctl.srch_start),
        .i_value   (r_cx),
        .i_nbins   (nx),
        .i_wr_en   (x_we),
        .i_wr_addr (x_wa),
        .i_wr_data (x_wd),
        .o_stat    (x_stat),
        .o_bin     (x_bin)
    );

    hbin_search #(
        .MAX_BINS (MAX_Y_BINS)
    ) u_ysrch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_ctl.srch_start),
        .i_value   (r_cy),
        .i_nbins   (ny),
        .i_wr_en   (y_we),
        .i_wr_addr (y_wa),
        .i_wr_data (y_wd),
        .o_stat    (y_stat),
        .o_bin     (y_bin)
    );

    // saturating add of the weight to the bin just read
    assign sum_ext = {bin_rd_data[BIN_W-1], bin_rd_data}
                   + {{(BIN_W + 1 - WEIGHT_W){r_w[WEIGHT_W-1]}}, r_w};
    assign sat_sum = (sum_ext[BIN_W] != sum_ext[BIN_W-1])
                   ? (sum_ext[BIN_W] ? BIN_MIN : BIN_MAX)
                   : sum_ext[BIN_W-1:0];

    assign bin_we = i_ctl.sweep || i_ctl.bin_upd;
    assign bin_wa = i_ctl.sweep ? r_sweep : r_baddr;
    assign bin_wd = i_ctl.sweep ? '0 : sat_sum;

    hbin_ram #(
        .WIDTH (BIN_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (bin_we),
        .i_wr_addr (bin_wa),
        .i_wr_data (bin_wd),
        .i_rd_en   (i_ctl.bin_rd),
        .i_rd_addr (r_baddr),
        .o_rd_data (bin_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xbins <= NBINS_RESET;
            r_ybins <= NBINS_RESET;
            r_sweep <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_X_BINS: r_xbins <= i_cfg_data;
                    CFG_Y_BINS: r_ybins <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_ctl.sweep) begin
                r_sweep <= sweep_last ? '0 : r_sweep + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_cx  <= i_coord_x;
            r_cy  <= i_coord_y;
            r_w   <= i_weight;
            r_ev  <= i_edge_value;
            r_ia  <= i_index_a;
            r_ib  <= i_index_b;
        end
        r_baddr <= (r_cmd == CMD_INC) ? inc_addr : rd_addr;
        if (i_ctl.out_load) begin
            r_status <= i_ctl.out_status;
            case (i_ctl.out_src)
                SRC_INC: begin
                    r_value <= sat_sum;
                    r_fx    <= FOUND_W'(x_bin);
                    r_fy    <= FOUND_W'(y_bin);
                end
                SRC_READ: begin
                    r_value <= bin_rd_data;
                    r_fx    <= '0;
                    r_fy    <= '0;
                end
                default: begin
                    r_value <= '0;
                    r_fx    <= '0;
                    r_fy    <= '0;
                end
            endcase
        end
    end

    assign o_sts = '{cmd:        r_cmd,
                     edge_ok:    edge_ok,
                     rd_ok:      rd_ok,
                     srch_done:  x_stat.done && y_stat.done,
                     x_ok:       x_stat.ok,
                     y_ok:       y_stat.ok,
                     sweep_last: sweep_last};

    assign o_status    = r_status;
    assign o_bin_value = $signed(r_value);
    assign o_found_x   = r_fx;
    assign o_found_y   = r_fy;

    a_port_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.bin_upd && i_ctl.sweep))
        else $error("bin update collides with the clearing sweep");

    a_inc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.out_load && (i_ctl.out_src == SRC_INC))
            |-> (x_stat.done && y_stat.done && x_stat.ok && y_stat.ok))
        else $error("increment result without both bins found");

endmodule

### rtl/core/histogram_2d_edge_search_binner_unit.sv
// Flow, input item to result item: an increment runs both axis edge searches at once,
//   one RAM probe per cycle each, and if both find a bin, reads and updates it; a
//   bin read reads it; an edge write, rejected read or unknown command goes to the
//   result; a clear sweeps all bins. One item in flight: the next item is taken only
//   once the last result is loaded; a result still held in the output stalls it.
// Reset (synchronous, active low): a sweep over all MAX_X_BINS*MAX_Y_BINS bins zeroes
//   the bins and loads edge i with i in Q16.16; no item is taken until it ends.
module histogram_2d_edge_search_binner_unit #(
    parameter int MAX_X_BINS = 64,
    parameter int MAX_Y_BINS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  hbin_pkg::t_cmd_code                  i_cmd,
    input  logic signed [hbin_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [hbin_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [hbin_pkg::WEIGHT_W-1:0] i_weight,
    input  logic signed [hbin_pkg::EDGE_W-1:0]   i_edge_value,
    input  logic [hbin_pkg::IDX_A_W-1:0]         i_index_a,
    input  logic [hbin_pkg::IDX_B_W-1:0]         i_index_b,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output hbin_pkg::t_status                    o_status,
    output logic signed [hbin_pkg::BIN_W-1:0]    o_bin_value,
    output logic [hbin_pkg::FOUND_W-1:0]         o_found_x,
    output logic [hbin_pkg::FOUND_W-1:0]         o_found_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  hbin_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [hbin_pkg::NBINS_W-1:0]         i_cfg_data
);

    import hbin_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_wr;

    // register writes are taken in any cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    hbin_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    hbin_dpath #(
        .MAX_X_BINS (MAX_X_BINS),
        .MAX_Y_BINS (MAX_Y_BINS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (dp_cmd),
        .o_sts        (dp_stat),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_weight     (i_weight),
        .i_edge_value (i_edge_value),
        .i_index_a    (i_index_a),
        .i_index_b    (i_index_b),
        .i_cfg_wr     (cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_status),
        .o_bin_value  (o_bin_value),
        .o_found_x    (o_found_x),
        .o_found_y    (o_found_y)
    );

endmodule

### dv/histogram_2d_edge_search_binner_unit_tb.sv
// Self-checking bench for the 2-D variable-edge histogram binner: drives edge
// writes, increments, reads and clears, and checks every result item.
// Depends on hbin_pkg and histogram_2d_edge_search_binner_unit.
`timescale 1ns / 100ps

module histogram_2d_edge_search_binner_unit_tb;

    import hbin_pkg::*;

    localparam int XMAX = 64;
    localparam int YMAX = 64;

    typedef struct {
        t_cmd_code                   cmd;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [WEIGHT_W-1:0]  weight;
        logic signed [EDGE_W-1:0]    edge_value;
        logic [IDX_A_W-1:0]          index_a;
        logic [IDX_B_W-1:0]          index_b;
    } t_hist_item;

    typedef struct {
        t_status                     status;
        logic signed [BIN_W-1:0]     bin_value;
        logic [FOUND_W-1:0]          found_x;
        logic [FOUND_W-1:0]          found_y;
    } t_bin_result;

    class bin_tracker;
        logic signed [EDGE_W-1:0] x_bounds [0:XMAX];
        logic signed [EDGE_W-1:0] y_bounds [0:YMAX];
        logic signed [BIN_W-1:0]  tallies [0:XMAX*YMAX-1];
        logic [NBINS_W-1:0]       x_bins_reg;
        logic [NBINS_W-1:0]       y_bins_reg;
        t_bin_result              awaited_results [$];
        int                       mismatches;

        function new();
            for (int i = 0; i <= XMAX; i++) x_bounds[i] = EDGE_W'(i << FRAC_W);
            for (int i = 0; i <= YMAX; i++) y_bounds[i] = EDGE_W'(i << FRAC_W);
            foreach (tallies[i]) tallies[i] = '0;
            x_bins_reg = NBINS_RESET;
            y_bins_reg = NBINS_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [NBINS_W-1:0] data);
            if (idx == CFG_X_BINS) x_bins_reg = data;
            else y_bins_reg = data;
        endfunction

        // Zero acts as one bin, anything above the maximum as the maximum
        function int bins_in_use(logic [NBINS_W-1:0] r, int maxn);
            if (r == 0) return 1;
            if (r > maxn) return maxn;
            return int'(r);
        endfunction

        function logic signed [EDGE_W-1:0] bound(bit on_y, int i);
            return on_y ? y_bounds[i] : x_bounds[i];
        endfunction

        function bit locate_axis(bit on_y, int n, logic signed [COORD_W-1:0] v,
                                 output int bin);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = n;
            if (v < bound(on_y, 0) || v >= bound(on_y, n)) return 1'b0;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (v >= bound(on_y, mid)) lo = mid;
                else hi = mid;
            end
            // tables need not ascend: recheck the bin the search landed on
            if (v < bound(on_y, lo) || v >= bound(on_y, lo + 1)) return 1'b0;
            bin = lo;
            return 1'b1;
        endfunction

        function void take_command(t_hist_item it);
            t_bin_result r;
            int nx;
            int ny;
            int bx;
            int by;
            int k;
            longint s;
            r.status = STAT_OK;
            r.bin_value = '0;
            r.found_x = '0;
            r.found_y = '0;
            nx = bins_in_use(x_bins_reg, XMAX);
            ny = bins_in_use(y_bins_reg, YMAX);
            case (it.cmd)
                CMD_WR_X: begin
                    if (it.index_a <= XMAX) x_bounds[it.index_a] = it.edge_value;
                    else r.status = STAT_BAD_INDEX;
                end
                CMD_WR_Y: begin
                    if (it.index_a <= YMAX) y_bounds[it.index_a] = it.edge_value;
                    else r.status = STAT_BAD_INDEX;
                end
                CMD_INC: begin
                    if (!locate_axis(1'b0, nx, it.coord_x, bx)) begin
                        r.status = STAT_X_RANGE;
                    end else if (!locate_axis(1'b1, ny, it.coord_y, by)) begin
                        r.status = STAT_Y_RANGE;
                    end else begin
                        k = bx * YMAX + by;
                        s = longint'(tallies[k]) + longint'(it.weight);
                        if (s > longint'($signed(BIN_MAX))) s = longint'($signed(BIN_MAX));
                        if (s < longint'($signed(BIN_MIN))) s = longint'($signed(BIN_MIN));
                        tallies[k] = s[BIN_W-1:0];
                        r.bin_value = s[BIN_W-1:0];
                        r.found_x = FOUND_W'(bx);
                        r.found_y = FOUND_W'(by);
                    end
                end
                CMD_READ: begin
                    if (int'(it.index_a) < nx && int'(it.index_b) < ny)
                        r.bin_value = tallies[int'(it.index_a) * YMAX + int'(it.index_b)];
                    else
                        r.status = STAT_BAD_INDEX;
                end
                CMD_CLEAR: begin
                    foreach (tallies[i]) tallies[i] = '0;
                end
                default: r.status = STAT_BAD_INDEX;
            endcase
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task match_result(t_bin_result got);
            t_bin_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result item with nothing awaited");
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.bin_value !== want.bin_value)
                report_mismatch($sformatf("bin_value %0d, want %0d",
                                          got.bin_value, want.bin_value));
            if (got.found_x !== want.found_x)
                report_mismatch($sformatf("found_x %0d, want %0d",
                                          got.found_x, want.found_x));
            if (got.found_y !== want.found_y)
                report_mismatch($sformatf("found_y %0d, want %0d",
                                          got.found_y, want.found_y));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    t_cmd_code                   i_cmd = CMD_WR_X;
    logic signed [COORD_W-1:0]   i_coord_x = '0;
    logic signed [COORD_W-1:0]   i_coord_y = '0;
    logic signed [WEIGHT_W-1:0]  i_weight = '0;
    logic signed [EDGE_W-1:0]    i_edge_value = '0;
    logic [IDX_A_W-1:0]          i_index_a = '0;
    logic [IDX_B_W-1:0]          i_index_b = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    t_status                     o_status;
    logic signed [BIN_W-1:0]     o_bin_value;
    logic [FOUND_W-1:0]          o_found_x;
    logic [FOUND_W-1:0]          o_found_y;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    t_cfg_idx                    i_cfg_index = CFG_X_BINS;
    logic [NBINS_W-1:0]          i_cfg_data = '0;

    bin_tracker tracker = new();

    int send_pct = 9;
    int recv_pct = 86;
    int item_count = 0;
    int drv_nx = XMAX;
    int drv_ny = YMAX;
    logic signed [EDGE_W-1:0] drv_x [0:XMAX];
    logic signed [EDGE_W-1:0] drv_y [0:YMAX];

    histogram_2d_edge_search_binner_unit #(
        .MAX_X_BINS (XMAX),
        .MAX_Y_BINS (YMAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_weight     (i_weight),
        .i_edge_value (i_edge_value),
        .i_index_a    (i_index_a),
        .i_index_b    (i_index_b),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_bin_value  (o_bin_value),
        .o_found_x    (o_found_x),
        .o_found_y    (o_found_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_pct);
    end

    // Note accepted items and register writes, check accepted results
    always @(posedge i_clk) begin
        t_hist_item  it;
        t_bin_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                it.cmd = i_cmd;
                it.coord_x = i_coord_x;
                it.coord_y = i_coord_y;
                it.weight = i_weight;
                it.edge_value = i_edge_value;
                it.index_a = i_index_a;
                it.index_b = i_index_b;
                tracker.take_command(it);
            end
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.bin_value = o_bin_value;
                got.found_x = o_found_x;
                got.found_y = o_found_y;
                tracker.match_result(got);
            end
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    function automatic int bins_of(logic [NBINS_W-1:0] r);
        if (r == 0) return 1;
        if (r > XMAX) return XMAX;
        return int'(r);
    endfunction

    function automatic logic signed [EDGE_W-1:0] drv_edge(bit on_y, int i);
        return on_y ? drv_y[i] : drv_x[i];
    endfunction

    function automatic t_hist_item rand_item();
        t_hist_item it;
        it.cmd = t_cmd_code'($urandom_range(0, 7));
        it.coord_x = $urandom;
        it.coord_y = $urandom;
        it.weight = $urandom;
        it.edge_value = $urandom;
        it.index_a = IDX_A_W'($urandom);
        it.index_b = IDX_B_W'($urandom);
        return it;
    endfunction

    function automatic t_hist_item mk(t_cmd_code c, logic [31:0] cx, logic [31:0] cy,
                                      logic [31:0] w, logic [31:0] ev, int ia, int ib);
        t_hist_item it;
        it.cmd = c;
        it.coord_x = cx;
        it.coord_y = cy;
        it.weight = w;
        it.edge_value = ev;
        it.index_a = IDX_A_W'(ia);
        it.index_b = IDX_B_W'(ib);
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(bit on_y);
        int     n;
        int     k;
        int     r;
        longint lo;
        longint span;
        n = on_y ? drv_ny : drv_nx;
        r = $urandom_range(99);
        if (r < 70) begin
            k = $urandom_range(0, n - 1);
            lo = longint'(drv_edge(on_y, k));
            span = longint'(drv_edge(on_y, k + 1)) - lo;
            if (span > 0) return COORD_W'(lo + longint'($urandom) % span);
            return COORD_W'(lo);
        end
        if (r < 82) return drv_edge(on_y, $urandom_range(0, n));
        if (r < 88) return drv_edge(on_y, 0) - 1;
        return $urandom;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 60) return WEIGHT_W'(int'($urandom_range(0, 200)) - 100);
        if (r < 80) return $urandom;
        if (r < 90) return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    function automatic logic [NBINS_W-1:0] pick_bins();
        int r;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0: if (r < 15) return 7'd0;
            1: if (r < 15) return 7'd127;
            2: if (r < 15) return 7'd64;
            default: if (r < 15) return 7'd1;
        endcase
        if (r < 80) return NBINS_W'($urandom_range(1, 6));
        return NBINS_W'($urandom_range(1, 64));
    endfunction

    function automatic t_hist_item random_work();
        t_hist_item it;
        int r;
        it = rand_item();
        r = $urandom_range(99);
        if (r < 55) begin
            it.cmd = CMD_INC;
            it.coord_x = pick_coord(1'b0);
            it.coord_y = pick_coord(1'b1);
            it.weight = pick_weight();
        end else if (r < 75) begin
            it.cmd = CMD_READ;
            if ($urandom_range(9) < 8) begin
                it.index_a = IDX_A_W'($urandom_range(0, drv_nx));
                it.index_b = IDX_B_W'($urandom_range(0, drv_ny > 63 ? 63 : drv_ny));
            end
        end else if (r < 82) begin
            it.cmd = $urandom_range(1) ? CMD_WR_Y : CMD_WR_X;
            if ($urandom_range(9) < 8) it.index_a = IDX_A_W'($urandom_range(0, XMAX));
            if ($urandom_range(1))
                it.edge_value = drv_edge(it.cmd == CMD_WR_Y,
                                         $urandom_range(0, XMAX)) + $urandom_range(0, 8) - 4;
        end else if (r < 83) begin
            it.cmd = CMD_CLEAR;
        end else if (r < 88) begin
            it.cmd = CMD_CLEAR + t_cmd_code'($urandom_range(1, 3));
        end
        return it;
    endfunction

    task automatic send_item(t_hist_item it);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= it.cmd;
        i_coord_x <= it.coord_x;
        i_coord_y <= it.coord_y;
        i_weight <= it.weight;
        i_edge_value <= it.edge_value;
        i_index_a <= it.index_a;
        i_index_b <= it.index_b;
        do @(posedge i_clk); while (!o_in_ready);
        // keep the generator's view of the edge tables in step
        if (it.cmd == CMD_WR_X && it.index_a <= XMAX) drv_x[it.index_a] = it.edge_value;
        if (it.cmd == CMD_WR_Y && it.index_a <= YMAX) drv_y[it.index_a] = it.edge_value;
        item_count++;
    endtask

    // Drop valid and hold until every awaited result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_bins(logic [NBINS_W-1:0] xv, logic [NBINS_W-1:0] yv);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_X_BINS;
        i_cfg_data <= xv;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_Y_BINS;
        i_cfg_data <= yv;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        drv_nx = bins_of(xv);
        drv_ny = bins_of(yv);
    endtask

    // Write an ascending edge table over the bins in use
    task automatic load_edges(bit on_y);
        t_hist_item it;
        int         n;
        int         max_step;
        bit         full_span;
        longint     e;
        n = on_y ? drv_ny : drv_nx;
        full_span = ($urandom_range(9) == 0);
        max_step = $urandom_range(1) ? 4 : (1 << 18);
        e = full_span ? -64'sd2147483648
                      : longint'($urandom_range(0, 1 << 25)) - (64'sd1 << 24);
        for (int i = 0; i <= n; i++) begin
            it = rand_item();
            it.cmd = on_y ? CMD_WR_Y : CMD_WR_X;
            it.index_a = IDX_A_W'(i);
            it.edge_value = (full_span && i == n) ? 32'h7FFF_FFFF : EDGE_W'(e);
            send_item(it);
            e = e + $urandom_range(1, max_step);
        end
    endtask

    task automatic run_directed();
        send_item(mk(CMD_INC, 32'h0, 32'h0, 32'd1, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h003F_FFFF, 32'h003F_0000, 32'h7FFF_FFFF, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h003F_FFFF, 32'h003F_0000, 32'h8000_0000, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h0040_0000, 32'h0, 32'd1, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'hFFFF_FFFF, 32'h0, 32'd1, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h0001_0000, 32'h7FFF_FFFF, 32'd1, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'h0, 0, 0));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 63, 63));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 64, 0));
        send_item(mk(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 127, 63));
        send_item(mk(CMD_WR_X, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 64, 0));
        send_item(mk(CMD_WR_X, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 65, 0));
        send_item(mk(CMD_WR_Y, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 127, 63));
        send_item(mk(CMD_WR_Y, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 0, 0));
        send_item(mk(CMD_INC, 32'h7FFF_FFFE, 32'h8000_0000, 32'd5, 32'h0, 0, 0));
        // break the order of the x table, then search across the break
        send_item(mk(CMD_WR_X, 32'h0, 32'h0, 32'h0, 32'h0064_0000, 5, 0));
        send_item(mk(CMD_INC, 32'h0005_8000, 32'h0002_0000, 32'd7, 32'h0, 0, 0));
        send_item(mk(CMD_INC, 32'h0032_0000, 32'h0002_0000, 32'd7, 32'h0, 0, 0));
        send_item(mk(CMD_CLEAR + 3'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 0, 0));
        send_item(mk(CMD_CLEAR + 3'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 127, 63));
        send_item(mk(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 63, 0));
        wait_idle();
        set_bins(7'd0, 7'd127);
        send_item(mk(CMD_INC, 32'h0000_8000, 32'h000A_8000, 32'd3, 32'h0, 0, 0));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0));
        wait_idle();
        set_bins(7'd127, 7'd0);
        send_item(mk(CMD_INC, 32'h7FFF_FFFE, 32'h8000_0000, 32'd9, 32'h0, 0, 0));
        send_item(mk(CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 63, 1));
    endtask

    task automatic run_episode();
        int n;
        wait_idle();
        set_bins(pick_bins(), pick_bins());
        load_edges(1'b0);
        load_edges(1'b1);
        n = $urandom_range(30, 90);
        repeat (n) send_item(random_work());
    endtask

    initial begin
        int start;
        for (int i = 0; i <= XMAX; i++) drv_x[i] = EDGE_W'(i << FRAC_W);
        for (int i = 0; i <= YMAX; i++) drv_y[i] = EDGE_W'(i << FRAC_W);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            send_pct = (phase == 0) ? 9 : (phase == 1) ? 86 : 0;
            recv_pct = (phase == 0) ? 86 : (phase == 1) ? 9 : 0;
            start = item_count;
            while (item_count - start < 565) run_episode();
        end
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("histogram_2d_edge_search_binner_unit_tb: PASS");
        end else begin
            $display("histogram_2d_edge_search_binner_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("histogram_2d_edge_search_binner_unit_tb: FAIL");
        $finish;
    end

endmodule
